// ----- hw/rtl/pcm_stream_deframer_assert.svh -----
// assertion macros shared by the deframer modules
`ifndef PCM_STREAM_DEFRAMER_ASSERT_SVH
`define PCM_STREAM_DEFRAMER_ASSERT_SVH

// same-cycle implication, checked at every clock edge outside reset
`define PSD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pcm deframer check failed");

// next-cycle implication, checked at every clock edge outside reset
`define PSD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pcm deframer check failed");

`endif

// ----- hw/rtl/pcm_sdf_pkg.sv -----
package pcm_sdf_pkg;

  // header layout and field values
  localparam int unsigned HDR_LEN      = 16;
  localparam int unsigned HDR_IDX_W    = $clog2(HDR_LEN);
  localparam logic [7:0]  HDR_VERSION  = 8'd1;
  localparam logic [7:0]  HDR_CHANNELS = 8'd1;
  localparam logic [7:0]  HDR_BITS     = 8'd16;

  // counter width for the announced sample count (20 to 32)
  localparam int unsigned COUNT_BITS = 32;

  // configuration reset values
  localparam logic [31:0] RATE_RESET  = 32'd16000;
  localparam logic [31:0] MAX_RESET   = RATE_RESET * 32'd60;

  // queue between front and back
  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);
  localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

  // configuration register indexes
  typedef enum logic {
    REG_RATE = 1'b0,
    REG_MAX  = 1'b1
  } reg_e;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_IDLE    = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    KIND_ACCEPT = 2'd0,
    KIND_REJECT = 2'd1,
    KIND_SAMPLE = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ERR_NONE    = 3'd0,
    ERR_MAGIC   = 3'd1,
    ERR_VERSION = 3'd2,
    ERR_FORMAT  = 3'd3,
    ERR_RATE    = 3'd4,
    ERR_COUNT   = 3'd5
  } err_e;

  // one classified byte travelling from front to back
  typedef struct packed {
    logic                 hdr;
    logic [HDR_IDX_W-1:0] idx;
    logic [7:0]           data;
  } op_t;

  // magic word, one byte per position
  function automatic logic [7:0] magic_byte(input logic [1:0] pos);
    logic [7:0] b;
    case (pos)
      2'd0:    b = 8'h41;
      2'd1:    b = 8'h50;
      2'd2:    b = 8'h41;
      default: b = 8'h49;
    endcase
    return b;
  endfunction

endpackage

// ----- hw/rtl/pcm_sdf_front.sv -----
module pcm_sdf_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [7:0]        data_byte_i,
  input  logic              stream_start_i,
  input  logic              q_full_i,
  output logic              push_o,
  output pcm_sdf_pkg::op_t  op_o
);
  import pcm_sdf_pkg::*;

  logic                 in_hdr_q, in_hdr_d;
  logic [HDR_IDX_W-1:0] idx_q, idx_d;
  logic                 accept;
  logic                 is_hdr;
  logic [HDR_IDX_W-1:0] cur_idx;

  // beats are taken whenever the queue has room
  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i & ~q_full_i;
  assign push_o     = accept;

  // a stream start forces header byte zero
  assign is_hdr  = stream_start_i | in_hdr_q;
  assign cur_idx = stream_start_i ? '0 : idx_q;

  assign op_o.hdr  = is_hdr;
  assign op_o.idx  = cur_idx;
  assign op_o.data = data_byte_i;

  // header position tracking
  always_comb begin
    in_hdr_d = in_hdr_q;
    idx_d    = idx_q;
    if (accept && is_hdr) begin
      if (cur_idx == HDR_IDX_W'(HDR_LEN - 1)) begin
        in_hdr_d = 1'b0;
        idx_d    = '0;
      end else begin
        in_hdr_d = 1'b1;
        idx_d    = cur_idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_hdr_q <= 1'b1;
      idx_q    <= '0;
    end else begin
      in_hdr_q <= in_hdr_d;
      idx_q    <= idx_d;
    end
  end

endmodule

// ----- hw/rtl/pcm_sdf_queue.sv -----
module pcm_sdf_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  pcm_sdf_pkg::op_t  op_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output pcm_sdf_pkg::op_t  op_o
);
  import pcm_sdf_pkg::*;

`include "pcm_stream_deframer_assert.svh"

  op_t                mem_q [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [Q_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [Q_CNT_W-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == Q_CNT_W'(Q_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign op_o    = mem_q[rd_ptr_q];

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= op_i;
    end
  end

  `PSD_ASSERT_NOW(a_no_push_full, full_o, !push_i)
  `PSD_ASSERT_NOW(a_no_pop_empty, !valid_o, !pop_i)
  `PSD_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_q <= Q_CNT_W'(Q_DEPTH))

endmodule

// ----- hw/rtl/pcm_sdf_back.sv -----
module pcm_sdf_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  input  pcm_sdf_pkg::op_t  op_i,
  output logic              pop_o,
  input  logic [31:0]       exp_rate_i,
  input  logic [31:0]       max_count_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [1:0]        result_kind_o,
  output logic [2:0]        status_code_o,
  output logic [31:0]       total_count_o,
  output logic signed [15:0] pcm_sample_o,
  output logic              last_sample_o
);
  import pcm_sdf_pkg::*;

`include "pcm_stream_deframer_assert.svh"

  phase_e                phase_q, phase_d;
  err_e                  err_q, err_d;
  logic [31:0]           rate_q, rate_d;
  logic [31:0]           cnt_q, cnt_d;
  logic [COUNT_BITS-1:0] remain_q, remain_d;
  logic [7:0]            low_q, low_d;
  logic                  parity_q, parity_d;

  logic                  out_valid_q, out_valid_d;
  kind_e                 kind_q, kind_d;
  err_e                  status_q, status_d;
  logic [31:0]           total_q, total_d;
  logic [15:0]           sample_q, sample_d;
  logic                  last_q, last_d;

  logic                  produce;
  logic                  hdr_end;
  logic [31:0]           rate_sh, cnt_sh;
  err_e                  err_base, err_now, err_new;
  logic                  cnt_bad;
  logic [COUNT_BITS-1:0] remain_dec;

  // take the next op once the output register is free or draining
  assign pop_o = q_valid_i & (~out_valid_q | ~out_stall_i);

  assign rate_sh    = {rate_q[23:0], op_i.data};
  assign cnt_sh     = {cnt_q[23:0], op_i.data};
  assign hdr_end    = (op_i.idx == HDR_IDX_W'(HDR_LEN - 1));
  assign remain_dec = remain_q - 1'b1;
  assign cnt_bad    = (cnt_sh == '0) || (cnt_sh > max_count_i) ||
                      (({1'b0, cnt_sh} >> COUNT_BITS) != '0);

  // check for this header byte
  always_comb begin
    err_now = ERR_NONE;
    case (op_i.idx)
      4'd0, 4'd1, 4'd2, 4'd3: begin
        if (op_i.data != magic_byte(op_i.idx[1:0])) err_now = ERR_MAGIC;
      end
      4'd4: begin
        if (op_i.data != HDR_VERSION) err_now = ERR_VERSION;
      end
      4'd5: begin
        if (op_i.data != HDR_CHANNELS) err_now = ERR_FORMAT;
      end
      4'd6: begin
        if (op_i.data != HDR_BITS) err_now = ERR_FORMAT;
      end
      4'd11: begin
        if (rate_sh != exp_rate_i) err_now = ERR_RATE;
      end
      4'd15: begin
        if (cnt_bad) err_now = ERR_COUNT;
      end
      default: err_now = ERR_NONE;
    endcase
  end

  // first failure wins, cleared on header byte zero
  assign err_base = (op_i.idx == '0) ? ERR_NONE : err_q;
  assign err_new  = (err_base != ERR_NONE) ? err_base : err_now;

  // parse phase next state
  always_comb begin
    phase_d = phase_q;
    if (pop_o) begin
      if (op_i.hdr) begin
        if (!hdr_end) begin
          phase_d = PH_HEADER;
        end else if (err_new != ERR_NONE) begin
          phase_d = PH_IDLE;
        end else begin
          phase_d = PH_PAYLOAD;
        end
      end else begin
        case (phase_q)
          PH_PAYLOAD: begin
            if (parity_q && remain_dec == '0) phase_d = PH_IDLE;
          end
          default: phase_d = phase_q;
        endcase
      end
    end
  end

  // datapath and result register
  always_comb begin
    err_d       = err_q;
    rate_d      = rate_q;
    cnt_d       = cnt_q;
    remain_d    = remain_q;
    low_d       = low_q;
    parity_d    = parity_q;
    produce     = 1'b0;
    kind_d      = kind_q;
    status_d    = status_q;
    total_d     = total_q;
    sample_d    = sample_q;
    last_d      = last_q;
    if (pop_o) begin
      if (op_i.hdr) begin
        err_d = err_new;
        case (op_i.idx)
          4'd8, 4'd9, 4'd10, 4'd11: rate_d = rate_sh;
          4'd12, 4'd13, 4'd14, 4'd15: cnt_d = cnt_sh;
          default: rate_d = rate_q;
        endcase
        if (hdr_end) begin
          produce  = 1'b1;
          sample_d = '0;
          last_d   = 1'b0;
          if (err_new != ERR_NONE) begin
            kind_d   = KIND_REJECT;
            status_d = err_new;
            total_d  = '0;
          end else begin
            kind_d   = KIND_ACCEPT;
            status_d = ERR_NONE;
            total_d  = cnt_sh;
            remain_d = cnt_sh[COUNT_BITS-1:0];
            parity_d = 1'b0;
          end
        end
      end else if (phase_q == PH_PAYLOAD) begin
        if (!parity_q) begin
          low_d    = op_i.data;
          parity_d = 1'b1;
        end else begin
          parity_d = 1'b0;
          remain_d = remain_dec;
          produce  = 1'b1;
          kind_d   = KIND_SAMPLE;
          status_d = ERR_NONE;
          total_d  = '0;
          sample_d = {op_i.data, low_q};
          last_d   = (remain_dec == '0);
        end
      end
    end
  end

  // output valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (produce) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HEADER;
      err_q       <= ERR_NONE;
      rate_q      <= '0;
      cnt_q       <= '0;
      remain_q    <= '0;
      parity_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      err_q       <= err_d;
      rate_q      <= rate_d;
      cnt_q       <= cnt_d;
      remain_q    <= remain_d;
      parity_q    <= parity_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    low_q    <= low_d;
    kind_q   <= kind_d;
    status_q <= status_d;
    total_q  <= total_d;
    sample_q <= sample_d;
    last_q   <= last_d;
  end

  assign out_valid_o   = out_valid_q;
  assign result_kind_o = kind_q;
  assign status_code_o = status_q;
  assign total_count_o = total_q;
  assign pcm_sample_o  = sample_q;
  assign last_sample_o = last_q;

  `PSD_ASSERT_NOW(a_payload_has_count, phase_q == PH_PAYLOAD, remain_q != '0)
  `PSD_ASSERT_NOW(a_reject_has_code, out_valid_q && kind_q == KIND_REJECT,
                  status_q != ERR_NONE)
  `PSD_ASSERT_NEXT(a_last_goes_idle,
                   pop_o && !op_i.hdr && phase_q == PH_PAYLOAD && parity_q &&
                   remain_q == COUNT_BITS'(1),
                   phase_q == PH_IDLE && out_valid_q && last_q)

endmodule

// ----- hw/rtl/pcm_stream_deframer.sv -----
// pcm stream deframer: one byte per beat in, header verdicts and samples out
// the beat that completes a result is stored in the queue, then the result is registered in the back end
// throughput: one byte per cycle while out_stall_i is low, held by the per-byte update in the back end
// a two-entry queue holds up to two beats while a result waits
// reset: asynchronous active low, parsing starts at header byte zero,
// rate and maximum count registers return to 16000 and 960000
module pcm_stream_deframer (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         data_byte_i,
  input  logic               stream_start_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         result_kind_o,
  output logic [2:0]         status_code_o,
  output logic [31:0]        total_count_o,
  output logic signed [15:0] pcm_sample_o,
  output logic               last_sample_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import pcm_sdf_pkg::*;

  logic [31:0] rate_q, rate_d;
  logic [31:0] max_q, max_d;
  logic        cfg_wr;
  reg_e        cfg_sel;

  logic        q_full, q_valid, push, pop;
  op_t         push_op, pop_op;

  // configuration registers
  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_sel = reg_e'(paddr[2]);

  always_comb begin
    rate_d = rate_q;
    max_d  = max_q;
    if (cfg_wr) begin
      case (cfg_sel)
        REG_RATE: rate_d = pwdata;
        REG_MAX:  max_d  = pwdata;
        default:  rate_d = rate_q;
      endcase
    end
  end

  always_comb begin
    case (cfg_sel)
      REG_RATE: prdata = rate_q;
      REG_MAX:  prdata = max_q;
      default:  prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q <= RATE_RESET;
      max_q  <= MAX_RESET;
    end else begin
      rate_q <= rate_d;
      max_q  <= max_d;
    end
  end

  // byte classification
  pcm_sdf_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .data_byte_i    (data_byte_i),
    .stream_start_i (stream_start_i),
    .q_full_i       (q_full),
    .push_o         (push),
    .op_o           (push_op)
  );

  // decoupling queue
  pcm_sdf_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .op_i    (push_op),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .op_o    (pop_op)
  );

  // header checks and sample assembly
  pcm_sdf_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .op_i          (pop_op),
    .pop_o         (pop),
    .exp_rate_i    (rate_q),
    .max_count_i   (max_q),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .result_kind_o (result_kind_o),
    .status_code_o (status_code_o),
    .total_count_o (total_count_o),
    .pcm_sample_o  (pcm_sample_o),
    .last_sample_o (last_sample_o)
  );

endmodule
